[src/igq_pkg.sv]
package igq_pkg;

  localparam int IN_FRAC_BITS = 32;
  localparam int Q_W          = IN_FRAC_BITS + 1;
  localparam int Z_W          = 32;
  localparam int WORK_BITS    = 28;
  localparam int LOG_STEPS    = 32;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = WORK_BITS + 2;

  // 2*ln(2) in Q1.30
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  // coefficients scaled by 10^6
  localparam logic [21:0] CC0 = 22'd2515517;
  localparam logic [19:0] CC1 = 20'd802853;
  localparam logic [13:0] CC2 = 14'd10328;
  localparam logic [19:0] DD0 = 20'd1000000;
  localparam logic [20:0] DD1 = 21'd1432788;
  localparam logic [17:0] DD2 = 18'd189269;
  localparam logic [10:0] DD3 = 11'd1308;

  typedef struct packed {
    logic err;
    logic fold;
  } side_t;

endpackage

[src/inverse_gaussian_q_approx_unit.sv]
// Inverse Gaussian tail value z = Q^-1(q) for q = in_q_code / 2^32, returned as signed Q4.28
// (out_z_value), with out_range_error set and zero returned when q is 0 or 1 or above. The unit
// is a fixed pipeline: one request is accepted every cycle while in_stall is low. The depth is
// set by the 32 squaring stages of the bit-serial log, the 32 stages of the square root and
// the 30 stages of the restoring divider. A two-entry output buffer lets the pipeline keep moving
// while one result waits; in_stall rises only when both entries are full and falls the cycle
// after the consumer takes a result.
module inverse_gaussian_q_approx_unit import igq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [Q_W-1:0]        in_q_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Z_W-1:0] out_z_value,
  output logic                  out_range_error
);

  logic sk_v_r, sk_v_nxt;
  logic en;
  assign en       = !sk_v_r;
  assign in_stall = sk_v_r;

  // ---------------- fold and range check
  logic        a_v_r;
  side_t       a_s_r, a_s_nxt;
  logic [31:0] a_x_r, a_x_nxt;

  always_comb begin
    a_s_nxt.err  = (in_q_code == '0) || in_q_code[Q_W-1];
    a_s_nxt.fold = !in_q_code[Q_W-1] && (in_q_code[31:0] > 32'h8000_0000);
    a_x_nxt      = a_s_nxt.fold ? (32'd0 - in_q_code[31:0]) : in_q_code[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s_r <= a_s_nxt;
      a_x_r <= a_x_nxt;
    end
  end

  // ---------------- normalize to a 30-bit-fraction mantissa
  logic [4:0]  b_p;
  logic [30:0] b_m;

  always_comb begin
    b_p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (a_x_r[i]) b_p = 5'(i);
    end
    if (b_p == 5'd31) b_m = a_x_r[31:1];
    else              b_m = 31'(a_x_r << (5'd30 - b_p));
  end

  logic        lv_r [0:LOG_STEPS];
  side_t       ls_r [0:LOG_STEPS];
  logic [30:0] lm_r [0:LOG_STEPS];
  logic [31:0] lf_r [0:LOG_STEPS];
  logic [5:0]  li_r [0:LOG_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r[0] <= 1'b0;
    end else if (en) begin
      lv_r[0] <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls_r[0] <= a_s_r;
      lm_r[0] <= b_m;
      lf_r[0] <= '0;
      li_r[0] <= 6'd32 - {1'b0, b_p};
    end
  end

  // one fraction bit of log2 per stage: square, renormalize
  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sqs;
    logic [31:0] fn;
    assign sq  = lm_r[k] * lm_r[k];
    assign sqs = sq[61:30];
    always_comb begin
      fn = lf_r[k];
      fn[LOG_STEPS-1-k] = sqs[31];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lv_r[k+1] <= 1'b0;
      end else if (en) begin
        lv_r[k+1] <= lv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ls_r[k+1] <= ls_r[k];
        li_r[k+1] <= li_r[k];
        lf_r[k+1] <= fn;
        lm_r[k+1] <= sqs[31] ? sqs[31:1] : sqs[30:0];
      end
    end
  end

  // ---------------- -2 ln x = -log2 x * 2 ln 2
  logic        u1_v_r;
  side_t       u1_s_r;
  logic [36:0] u1_ia_r;
  logic [32:0] u1_fb_r;
  logic [37:0] l2;
  logic [62:0] fprod;

  assign l2    = {li_r[LOG_STEPS], 32'd0} - {6'd0, lf_r[LOG_STEPS]};
  assign fprod = l2[31:0] * TWO_LN2_Q30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_v_r <= 1'b0;
    end else if (en) begin
      u1_v_r <= lv_r[LOG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_s_r  <= ls_r[LOG_STEPS];
      u1_ia_r <= l2[37:32] * TWO_LN2_Q30;
      u1_fb_r <= fprod[62:30];
    end
  end

  // ---------------- integer square root, one result bit per stage
  logic        sqv_r [0:SQRT_STEPS];
  side_t       sqs_r [0:SQRT_STEPS];
  logic [62:0] sv_r  [0:SQRT_STEPS];
  logic [62:0] sr_r  [0:SQRT_STEPS];
  logic [39:0] u_sum;

  assign u_sum = {1'b0, u1_ia_r, 2'b00} + 40'(u1_fb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r[0] <= 1'b0;
    end else if (en) begin
      sqv_r[0] <= u1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqs_r[0] <= u1_s_r;
      sv_r[0]  <= 63'(u_sum) << (2 * WORK_BITS - LOG_STEPS);
      sr_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
    logic [62:0] trial;
    logic        ge;
    assign trial = sr_r[k] + BIT;
    assign ge    = sv_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k+1] <= 1'b0;
      end else if (en) begin
        sqv_r[k+1] <= sqv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqs_r[k+1] <= sqs_r[k];
        sv_r[k+1]  <= ge ? (sv_r[k] - trial) : sv_r[k];
        sr_r[k+1]  <= ge ? ((sr_r[k] >> 1) + BIT) : (sr_r[k] >> 1);
      end
    end
  end

  // ---------------- numerator and denominator polynomials
  logic [30:0] t_sq;
  assign t_sq = sr_r[SQRT_STEPS][30:0];

  logic        p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  side_t       p1_s_r, p2_s_r, p3_s_r, p4_s_r;
  logic [30:0] p1_t_r, p2_t_r, p3_t_r, p4_t_r;
  logic [47:0] p1_n_r;
  logic [46:0] p1_d_r;
  logic [50:0] p2_nh_r;
  logic [30:0] p2_nl_r;
  logic [49:0] p2_dh_r;
  logic [30:0] p2_dl_r;
  logic [51:0] p3_n_r, p4_n_r;
  logic [50:0] p3_d_r;
  logic [53:0] p4_dh_r;
  logic [30:0] p4_dl_r;
  logic [58:0] p2_nlp, p2_dlp, p4_dlp;

  assign p2_nlp = p1_n_r[27:0] * p1_t_r;
  assign p2_dlp = p1_d_r[27:0] * p1_t_r;
  assign p4_dlp = p3_d_r[27:0] * p3_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= sqv_r[SQRT_STEPS];
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_s_r  <= sqs_r[SQRT_STEPS];
      p1_t_r  <= t_sq;
      p1_n_r  <= 48'(CC2) * 48'(t_sq) + (48'(CC1) << WORK_BITS);
      p1_d_r  <= 47'(DD3) * 47'(t_sq) + (47'(DD2) << WORK_BITS);
      p2_s_r  <= p1_s_r;
      p2_t_r  <= p1_t_r;
      p2_nh_r <= p1_n_r[47:28] * p1_t_r;
      p2_nl_r <= p2_nlp[58:28];
      p2_dh_r <= p1_d_r[46:28] * p1_t_r;
      p2_dl_r <= p2_dlp[58:28];
      p3_s_r  <= p2_s_r;
      p3_t_r  <= p2_t_r;
      p3_n_r  <= 52'(p2_nh_r) + 52'(p2_nl_r) + (52'(CC0) << WORK_BITS);
      p3_d_r  <= 51'(p2_dh_r) + 51'(p2_dl_r) + (51'(DD1) << WORK_BITS);
      p4_s_r  <= p3_s_r;
      p4_t_r  <= p3_t_r;
      p4_n_r  <= p3_n_r;
      p4_dh_r <= p3_d_r[50:28] * p3_t_r;
      p4_dl_r <= p4_dlp[58:28];
    end
  end

  // ---------------- restoring divider; divisor held doubled so every step is alike
  logic                 dv_r  [0:DIV_STEPS];
  side_t                ds_r  [0:DIV_STEPS];
  logic [30:0]          dt_r  [0:DIV_STEPS];
  logic [54:0]          dd_r  [0:DIV_STEPS];
  logic [55:0]          rem_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qt_r  [0:DIV_STEPS];
  logic [54:0]          den;

  assign den = 55'(p4_dh_r) + 55'(p4_dl_r) + (55'(DD0) << WORK_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r[0]  <= p4_s_r;
      dt_r[0]  <= p4_t_r;
      dd_r[0]  <= {den[53:0], 1'b0};
      rem_r[0] <= 56'(p4_n_r);
      qt_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic        ge;
    logic [55:0] rn;
    assign ge = rem_r[k] >= {1'b0, dd_r[k]};
    assign rn = ge ? (rem_r[k] - {1'b0, dd_r[k]}) : rem_r[k];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[k+1]  <= ds_r[k];
        dt_r[k+1]  <= dt_r[k];
        dd_r[k+1]  <= dd_r[k];
        rem_r[k+1] <= {rn[54:0], 1'b0};
        qt_r[k+1]  <= {qt_r[k][DIV_STEPS-2:0], ge};
      end
    end
  end

  // ---------------- z = t - zeta, sign fixup
  logic           f_v_r;
  logic [Z_W-1:0] f_z_r, f_z_nxt;
  logic           f_e_r;
  logic [30:0]    f_t, f_q, f_mag;
  logic           f_lt, f_neg;

  always_comb begin
    f_t   = dt_r[DIV_STEPS];
    f_q   = {1'b0, qt_r[DIV_STEPS]};
    f_lt  = f_t < f_q;
    f_mag = f_lt ? (f_q - f_t) : (f_t - f_q);
    f_neg = f_lt ^ ds_r[DIV_STEPS].fold;
    if (ds_r[DIV_STEPS].err) f_z_nxt = '0;
    else if (f_neg)          f_z_nxt = Z_W'(0) - {1'b0, f_mag};
    else                     f_z_nxt = {1'b0, f_mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_z_r <= f_z_nxt;
      f_e_r <= ds_r[DIV_STEPS].err;
    end
  end

  // ---------------- output register plus skid entry
  logic           out_v_r, out_v_nxt;
  logic [Z_W-1:0] out_z_r, sk_z_r;
  logic           out_e_r, sk_e_r;
  logic           take, load_out, load_sk, out_from_sk;

  always_comb begin
    take        = out_v_r && !out_stall;
    out_v_nxt   = out_v_r;
    sk_v_nxt    = sk_v_r;
    load_out    = 1'b0;
    load_sk     = 1'b0;
    out_from_sk = 1'b0;
    if (en) begin
      if (!out_v_r || take) begin
        out_v_nxt = f_v_r;
        load_out  = 1'b1;
      end else if (f_v_r) begin
        sk_v_nxt = 1'b1;
        load_sk  = 1'b1;
      end
    end else if (take) begin
      sk_v_nxt    = 1'b0;
      out_from_sk = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_z_r <= f_z_r;
      out_e_r <= f_e_r;
    end else if (out_from_sk) begin
      out_z_r <= sk_z_r;
      out_e_r <= sk_e_r;
    end
    if (load_sk) begin
      sk_z_r <= f_z_r;
      sk_e_r <= f_e_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_z_value     = out_z_r;
  assign out_range_error = out_e_r;

endmodule

[src/igq_checker.sv]
module igq_checker import igq_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [Q_W-1:0]        in_q_code,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic signed [Z_W-1:0] out_z_value,
  input logic                  out_range_error
);

  // error results always carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_z_value == '0)
    else $error("range error with nonzero value");

  // input backpressure only while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output empty");

  // draining one result always frees the input
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input still stalled after a result was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_z_value) && $stable(out_range_error))
    else $error("stalled result changed");

  // a stalled request stays put until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_q_code))
    else $error("stalled request changed");

endmodule

bind inverse_gaussian_q_approx_unit igq_checker u_igq_checker (.*);

[tb/sv/inverse_gaussian_q_approx_unit_tb.sv]
module inverse_gaussian_q_approx_unit_tb;
  import igq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [Q_W-1:0]        in_q_code;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [Z_W-1:0] out_z_value;
  logic                  out_range_error;

  typedef struct {
    logic signed [Z_W-1:0] z;
    logic                  err;
  } tail_result_t;

  tail_result_t pending_z[$];
  int unsigned  fail_count;
  int unsigned  sent_count;
  int unsigned  got_count;
  int unsigned  err_count;
  int unsigned  cycle_count;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  hold_off;

  inverse_gaussian_q_approx_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_q_code(in_q_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_z_value(out_z_value), .out_range_error(out_range_error)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---- predictor ----
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // -log2(x / 2^32) with 32 fraction bits
  function automatic logic [63:0] minus_log2(input logic [63:0] x);
    int p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 63;
    frac = 0;
    while (p > 0 && !x[p]) p--;
    if (p > 30) m = x >> (p - 30);
    else m = x << (30 - p);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(32 - p) << 32) - frac;
  endfunction

  function automatic logic [63:0] mul_work(input logic [63:0] a, input logic [63:0] b);
    return (a >> WORK_BITS) * b + (((a & ((64'd1 << WORK_BITS) - 1)) * b) >> WORK_BITS);
  endfunction

  function automatic tail_result_t tail_value(input logic [Q_W-1:0] q);
    tail_result_t r;
    logic [63:0] one, x, l2, u, t, num, den, quo, rem, mag;
    logic folded, neg;
    one = 64'd1 << IN_FRAC_BITS;
    r.z = '0;
    r.err = 1'b1;
    if (q == 0 || 64'(q) >= one) return r;
    folded = 64'(q) > (one >> 1);
    x = folded ? one - 64'(q) : 64'(q);
    l2 = minus_log2(x);
    u = (((l2 >> 32) * 64'(TWO_LN2_Q30)) << 2) + (((l2 & 64'hFFFF_FFFF) * 64'(TWO_LN2_Q30)) >> 30);
    t = int_sqrt(u << (2 * WORK_BITS - 32));
    num = 64'(CC2) * t + (64'(CC1) << WORK_BITS);
    num = mul_work(num, t) + (64'(CC0) << WORK_BITS);
    den = 64'(DD3) * t + (64'(DD2) << WORK_BITS);
    den = mul_work(den, t) + (64'(DD1) << WORK_BITS);
    den = mul_work(den, t) + (64'(DD0) << WORK_BITS);
    quo = num / den;
    rem = num - quo * den;
    for (int i = 0; i < WORK_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    if (t >= quo) begin
      mag = t - quo;
      neg = 1'b0;
    end else begin
      mag = quo - t;
      neg = 1'b1;
    end
    if (folded) neg = !neg;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      r.z = -mag[31:0];
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      r.z = mag[31:0];
    end
    r.err = 1'b0;
    return r;
  endfunction

  // ---- request side ----
  task automatic send_q(input logic [Q_W-1:0] q);
    in_valid <= 1'b1;
    in_q_code <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_z.push_back(tail_value(q));
    sent_count++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // spread over the whole range, the tails and the fold point
  function automatic logic [Q_W-1:0] pick_q();
    logic [Q_W-1:0] q;
    case ($urandom_range(9))
      0:       q = Q_W'({$urandom(), $urandom()});
      1:       q = 33'($urandom_range(1, 65535));
      2:       q = (33'd1 << 32) - 33'($urandom_range(1, 65535));
      3:       q = (33'd1 << 31) + 33'($urandom_range(0, 512)) - 33'd256;
      4:       q = 33'($urandom()) >> $urandom_range(0, 31);
      5:       q = (33'd1 << 32) - (33'($urandom()) >> $urandom_range(0, 31));
      default: q = {1'b0, $urandom()};
    endcase
    return q;
  endfunction

  // ---- result side ----
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s at result %0d: got %0h, expected %0h", what, got_count, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tail_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_z.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_z_value), 64'd0);
      end else begin
        want = pending_z.pop_front();
        if (out_z_value !== want.z)
          report_mismatch("z_value", 64'(out_z_value), 64'(want.z));
        if (out_range_error !== want.err)
          report_mismatch("range_error", 64'(out_range_error), 64'(want.err));
        if (want.err) err_count++;
      end
      got_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---- tests ----
  task automatic test_edges();
    logic [Q_W-1:0] edge_q[$];
    edge_q = '{33'd0, 33'd1, 33'd2, 33'd3, 33'd1000, 33'h0001_0000, 33'h0FFF_FFFF,
               33'h7FFF_FFFF, 33'h8000_0000, 33'h8000_0001, 33'h8000_0002,
               33'hBFFF_FFFF, 33'hF000_0000, 33'hFFFF_FFFE, 33'hFFFF_FFFF,
               33'h1_0000_0000, 33'h1_0000_0001, 33'h1_8000_0000, 33'h1_FFFF_FFFF,
               33'h4000_0000, 33'hC000_0000, 33'h5555_5555, 33'hAAAA_AAAA};
    foreach (edge_q[i]) send_q(edge_q[i]);
  endtask

  task automatic test_random(input int unsigned n, input int unsigned tx_pct,
                             input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) send_q(pick_q());
  endtask

  // more requests than the pipeline holds, so the input has to stall
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off <= 400;
    repeat (150) send_q(pick_q());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_q_code <= '0;
    out_stall <= 1'b0;
    hold_off = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fail_count = 0;
    sent_count = 0;
    got_count = 0;
    err_count = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges();
    test_random(260, 15, 62);
    test_random(260, 62, 15);
    test_random(260, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    rx_idle_pct = 10;

    while (pending_z.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d probabilities (edges, tails, fold point, out of range)", sent_count);
    $display("Checked %0d results, %0d range errors, under idling and long hold-off",
             got_count, err_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[inverse_gaussian_q_approx_unit.f]
src/igq_pkg.sv
src/inverse_gaussian_q_approx_unit.sv
src/igq_checker.sv
tb/sv/inverse_gaussian_q_approx_unit_tb.sv
